FILE: rtl/core/gbn_pkg.sv
package gbn_pkg;

	localparam int MAX_PAYLOAD  = 53;
	localparam int PACKET_BYTES = 64;
	localparam int HDR_LEN      = 11;
	localparam int CSUM_HI      = 9;
	localparam int CSUM_LO      = 10;
	localparam int SEQ_FIRST    = 1;
	localparam int SEQ_LAST     = 4;

	localparam int BYTE_W  = 8;
	localparam int MSIZE_W = 6;
	localparam int ACK_W   = 32;
	localparam int CS_W    = 16;
	localparam int SUM_W   = 22;
	localparam int IDX_W   = $clog2(PACKET_BYTES);
	localparam int PAY_AW  = $clog2(MAX_PAYLOAD);
	localparam int LAST_IDX = PACKET_BYTES - 1;

	typedef enum logic [2:0] {
		ST_RECV,
		ST_CHECK,
		ST_JUDGE,
		ST_PAY,
		ST_ACKCS,
		ST_ACK
	} gbn_state_t;

	typedef struct packed {
		logic take;
		logic fold_sum;
		logic clear_sum;
		logic load_ack_prev;
		logic load_ack_seq;
		logic pay_start;
		logic pay_advance;
		logic ack_csum;
		logic emit_ack;
	} gbn_cmd_t;

	typedef struct packed {
		logic last_byte;
		logic good;
		logic seq_match;
		logic exp_ge2;
		logic size_zero;
		logic pay_done;
	} gbn_sts_t;

endpackage

FILE: rtl/core/gbn_ifs.sv
interface gbn_in_if import gbn_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface gbn_out_if import gbn_pkg::*; ;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [BYTE_W-1:0]  data_byte;
	logic [MSIZE_W-1:0] message_size;
	logic [ACK_W-1:0]   ack_number;
	logic [CS_W-1:0]    ack_checksum;
	logic               last;

	modport source (output valid, output kind, output data_byte, output message_size,
		output ack_number, output ack_checksum, output last, input ready);
	modport sink (input valid, input kind, input data_byte, input message_size,
		input ack_number, input ack_checksum, input last, output ready);
endinterface

FILE: rtl/core/gbn_dp.sv
module gbn_dp import gbn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  gbn_cmd_t           cmd,
	input  logic [BYTE_W-1:0]  rx_byte,
	output gbn_sts_t           sts,
	output logic               kind,
	output logic [BYTE_W-1:0]  data_byte,
	output logic [MSIZE_W-1:0] message_size,
	output logic [ACK_W-1:0]   ack_number,
	output logic [CS_W-1:0]    ack_checksum,
	output logic               last
);

	logic [IDX_W-1:0]  idx_q;
	logic [SUM_W-1:0]  sum_q;
	logic [ACK_W-1:0]  seq_q;
	logic [BYTE_W-1:0] size_q;
	logic [CS_W-1:0]   sent_q;
	logic [ACK_W-1:0]  exp_q;
	logic [CS_W:0]     fold_q;
	logic [ACK_W-1:0]  ack_num_q;
	logic [CS_W-1:0]   ack_cs_q;
	logic [PAY_AW-1:0] pay_cnt_q;
	logic [BYTE_W-1:0] rd_data_q;
	logic [BYTE_W-1:0] mem_q [MAX_PAYLOAD];

	logic              csum_byte;
	logic [SUM_W-1:0]  addend;
	logic [PAY_AW-1:0] wr_addr;
	logic [PAY_AW-1:0] rd_addr;
	logic [CS_W-1:0]   fold2;
	logic [CS_W:0]     ack_s;

	assign csum_byte = (idx_q == IDX_W'(CSUM_HI)) || (idx_q == IDX_W'(CSUM_LO));
	// odd positions count as the high byte of a 16-bit word
	assign addend = idx_q[0] ? SUM_W'({rx_byte, 8'h00}) : SUM_W'(rx_byte);
	assign wr_addr = PAY_AW'(idx_q - IDX_W'(HDR_LEN));
	assign ack_s = {1'b0, ack_num_q[ACK_W-1:CS_W]} + {1'b0, ack_num_q[CS_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			sum_q <= '0;
			seq_q <= '0;
			size_q <= '0;
			sent_q <= '0;
			exp_q <= ACK_W'(1);
		end else begin
			if (cmd.take) begin
				idx_q <= idx_q + IDX_W'(1);
				if (idx_q == '0)
					size_q <= rx_byte;
				if (idx_q >= IDX_W'(SEQ_FIRST) && idx_q <= IDX_W'(SEQ_LAST))
					seq_q <= {seq_q[ACK_W-BYTE_W-1:0], rx_byte};
				if (idx_q == IDX_W'(CSUM_HI))
					sent_q <= {rx_byte, 8'h00};
				if (idx_q == IDX_W'(CSUM_LO))
					sent_q[BYTE_W-1:0] <= rx_byte;
			end
			if (cmd.clear_sum)
				sum_q <= '0;
			else if (cmd.take && !csum_byte)
				sum_q <= sum_q + addend;
			if (cmd.load_ack_seq)
				exp_q <= exp_q + ACK_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fold_sum)
			fold_q <= {1'b0, sum_q[CS_W-1:0]} + (CS_W+1)'(sum_q[SUM_W-1:CS_W]);
		if (cmd.load_ack_prev)
			ack_num_q <= exp_q - ACK_W'(1);
		else if (cmd.load_ack_seq)
			ack_num_q <= seq_q;
		if (cmd.ack_csum)
			ack_cs_q <= ~(ack_s[CS_W-1:0] + CS_W'(ack_s[CS_W]));
		if (cmd.pay_start)
			pay_cnt_q <= '0;
		else if (cmd.pay_advance)
			pay_cnt_q <= pay_cnt_q + PAY_AW'(1);
	end

	// payload buffer, one write port and one registered read port
	always_comb begin
		priority if (cmd.pay_start)
			rd_addr = '0;
		else if (cmd.pay_advance)
			rd_addr = pay_cnt_q + PAY_AW'(1);
		else
			rd_addr = pay_cnt_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.take && idx_q >= IDX_W'(HDR_LEN))
			mem_q[wr_addr] <= rx_byte;
		if (rd_addr < PAY_AW'(MAX_PAYLOAD))
			rd_data_q <= mem_q[rd_addr];
	end

	assign fold2 = fold_q[CS_W-1:0] + CS_W'(fold_q[CS_W]);

	always_comb begin
		sts.last_byte = (idx_q == IDX_W'(LAST_IDX));
		sts.good = (size_q <= BYTE_W'(MAX_PAYLOAD)) && (~fold2 == sent_q);
		sts.seq_match = (seq_q == exp_q);
		sts.exp_ge2 = (exp_q > ACK_W'(1));
		sts.size_zero = (size_q == '0);
		sts.pay_done = ((pay_cnt_q + PAY_AW'(1)) == size_q[PAY_AW-1:0]);
	end

	assign kind = cmd.emit_ack;
	assign data_byte = cmd.emit_ack ? '0 : rd_data_q;
	assign message_size = cmd.emit_ack ? '0 : size_q[MSIZE_W-1:0];
	assign ack_number = cmd.emit_ack ? ack_num_q : '0;
	assign ack_checksum = cmd.emit_ack ? ack_cs_q : '0;
	assign last = cmd.emit_ack;

endmodule

FILE: rtl/core/gbn_ctrl.sv
module gbn_ctrl import gbn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     rx_valid,
	output logic     rx_ready,
	output logic     tx_valid,
	input  logic     tx_ready,
	input  gbn_sts_t sts,
	output gbn_cmd_t cmd
);

	gbn_state_t state_q;
	gbn_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_RECV;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RECV: begin
				if (rx_valid && sts.last_byte)
					state_d = ST_CHECK;
			end
			ST_CHECK: state_d = ST_JUDGE;
			ST_JUDGE: begin
				priority if (!sts.good && !sts.exp_ge2)
					state_d = ST_RECV;
				else if (!sts.good || !sts.seq_match || sts.size_zero)
					state_d = ST_ACKCS;
				else
					state_d = ST_PAY;
			end
			ST_PAY: begin
				if (tx_ready && sts.pay_done)
					state_d = ST_ACKCS;
			end
			ST_ACKCS: state_d = ST_ACK;
			ST_ACK: begin
				if (tx_ready)
					state_d = ST_RECV;
			end
			default: state_d = ST_RECV;
		endcase
	end

	always_comb begin
		cmd = '0;
		rx_ready = 1'b0;
		tx_valid = 1'b0;
		unique case (state_q)
			ST_RECV: begin
				rx_ready = 1'b1;
				cmd.take = rx_valid;
			end
			ST_CHECK: cmd.fold_sum = 1'b1;
			ST_JUDGE: begin
				cmd.clear_sum = 1'b1;
				priority if (!sts.good || !sts.seq_match)
					cmd.load_ack_prev = sts.exp_ge2 || sts.good;
				else if (sts.size_zero)
					cmd.load_ack_seq = 1'b1;
				else
					cmd.pay_start = 1'b1;
			end
			ST_PAY: begin
				tx_valid = 1'b1;
				cmd.pay_advance = tx_ready;
				cmd.load_ack_seq = tx_ready && sts.pay_done;
			end
			ST_ACKCS: cmd.ack_csum = 1'b1;
			ST_ACK: begin
				tx_valid = 1'b1;
				cmd.emit_ack = 1'b1;
			end
			default: cmd = '0;
		endcase
	end

`ifndef SYNTH
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(rx_ready && tx_valid))
		else $error("input and output open at once");
	a_end_of_packet: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && sts.last_byte) |=> (state_q == ST_CHECK))
		else $error("final beat did not start the check");
	a_pay_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAY) |-> (sts.good && sts.seq_match && !sts.size_zero))
		else $error("payload delivered for a packet that is not good and in order");
	a_ack_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACKCS) |=> (state_q == ST_ACK))
		else $error("acknowledgement not offered after checksum");
`endif

endmodule

FILE: rtl/core/go_back_n_packet_receiver.sv
// Go-back-N receiver: takes 64-byte packets one beat per byte on rx (byte 0 = size,
// 1..4 sequence number big-endian, 9..10 checksum, 11..63 payload) and answers on tx.
// A good in-order packet yields its payload bytes (kind 0) followed by an ACK of its
// sequence number (kind 1, last set); a good out-of-order packet yields an ACK of the
// expected number minus one; a corrupt packet yields that same ACK only once the
// expected number has passed 1. Bytes are taken one per cycle while no result is
// pending; after the final byte the controller checks the packet (states CHECK and
// JUDGE), then offers the payload beats from the single registered read port of the
// payload buffer, then forms and offers the ACK (states ACKCS and ACK). Input is held
// off until the last result of a packet has been taken.
module go_back_n_packet_receiver import gbn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	gbn_in_if.sink rx,
	gbn_out_if.source tx
);

	gbn_cmd_t cmd;
	gbn_sts_t sts;

	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx.ready),
		.tx_valid (tx.valid),
		.tx_ready (tx.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gbn_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.rx_byte      (rx.rx_byte),
		.sts          (sts),
		.kind         (tx.kind),
		.data_byte    (tx.data_byte),
		.message_size (tx.message_size),
		.ack_number   (tx.ack_number),
		.ack_checksum (tx.ack_checksum),
		.last         (tx.last)
	);

endmodule

FILE: verif/gbn_rx_checker.sv
module gbn_rx_checker import gbn_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	gbn_in_if    rx,
	gbn_out_if   tx,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic               kind;
		logic [BYTE_W-1:0]  data_byte;
		logic [MSIZE_W-1:0] message_size;
		logic [ACK_W-1:0]   ack_number;
		logic [CS_W-1:0]    ack_checksum;
		logic               last;
	} gbn_result_t;

	gbn_result_t        result_q[$];
	logic [IDX_W-1:0]   pos;
	logic [SUM_W-1:0]   sum_acc;
	logic [ACK_W-1:0]   seq_cap;
	logic [BYTE_W-1:0]  size_cap;
	logic [CS_W-1:0]    csum_rx;
	logic [ACK_W-1:0]   seq_expected;
	logic [BYTE_W-1:0]  payload [MAX_PAYLOAD];

	function automatic logic [CS_W-1:0] fold_invert(input logic [31:0] s);
		logic [31:0] t;
		t = {16'h0, s[31:16]} + {16'h0, s[15:0]};
		t = {16'h0, t[31:16]} + {16'h0, t[15:0]};
		return ~t[15:0];
	endfunction

	// ACK packet: only the ack number bytes 5..8 are nonzero
	function automatic gbn_result_t ack_result(input logic [ACK_W-1:0] n);
		gbn_result_t r;
		logic [31:0] s;
		s = {16'h0, n[31:24], 8'h00} + {24'h0, n[23:16]}
			+ {16'h0, n[15:8], 8'h00} + {24'h0, n[7:0]};
		r = '0;
		r.kind = 1'b1;
		r.ack_number = n;
		r.ack_checksum = fold_invert(s);
		r.last = 1'b1;
		return r;
	endfunction

	task automatic absorb_byte(input logic [BYTE_W-1:0] b);
		gbn_result_t r;
		logic [SUM_W-1:0] s;
		bit good;
		s = sum_acc;
		if (pos != CSUM_HI && pos != CSUM_LO)
			s = pos[0] ? s + {b, 8'h00} : s + b;
		if (pos == 0)
			size_cap = b;
		else if (pos <= SEQ_LAST)
			seq_cap = {seq_cap[23:0], b};
		else if (pos == CSUM_HI)
			csum_rx = {b, 8'h00};
		else if (pos == CSUM_LO)
			csum_rx[7:0] = b;
		else if (pos >= HDR_LEN)
			payload[pos - HDR_LEN] = b;
		sum_acc = s;
		if (pos == LAST_IDX) begin
			sum_acc = '0;
			good = size_cap <= MAX_PAYLOAD && fold_invert(32'(s)) == csum_rx;
			if (!good) begin
				if (seq_expected >= 2)
					result_q.push_back(ack_result(seq_expected - 1));
			end else if (seq_cap != seq_expected) begin
				result_q.push_back(ack_result(seq_expected - 1));
			end else begin
				for (int i = 0; i < size_cap; i++) begin
					r = '0;
					r.data_byte = payload[i];
					r.message_size = size_cap[MSIZE_W-1:0];
					result_q.push_back(r);
				end
				result_q.push_back(ack_result(seq_cap));
				seq_expected = seq_expected + 1;
			end
		end
		pos = pos + 1'b1;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		errors++;
		if (errors <= 40)
			$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	task automatic check_result(input gbn_result_t got);
		gbn_result_t want;
		if (result_q.size() == 0) begin
			report_mismatch("result beat with nothing expected", got.ack_number, 0);
		end else begin
			want = result_q.pop_front();
			if (got.kind !== want.kind)
				report_mismatch("kind", 32'(got.kind), 32'(want.kind));
			if (got.data_byte !== want.data_byte)
				report_mismatch("data_byte", 32'(got.data_byte), 32'(want.data_byte));
			if (got.message_size !== want.message_size)
				report_mismatch("message_size", 32'(got.message_size),
					32'(want.message_size));
			if (got.ack_number !== want.ack_number)
				report_mismatch("ack_number", got.ack_number, want.ack_number);
			if (got.ack_checksum !== want.ack_checksum)
				report_mismatch("ack_checksum", 32'(got.ack_checksum),
					32'(want.ack_checksum));
			if (got.last !== want.last)
				report_mismatch("last", 32'(got.last), 32'(want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		gbn_result_t beat;
		if (!arst_n) begin
			result_q.delete();
			pos = '0;
			sum_acc = '0;
			seq_cap = '0;
			size_cap = '0;
			csum_rx = '0;
			seq_expected = 1;
			errors = 0;
			pending <= 0;
		end else begin
			if (tx.valid && tx.ready) begin
				beat.kind = tx.kind;
				beat.data_byte = tx.data_byte;
				beat.message_size = tx.message_size;
				beat.ack_number = tx.ack_number;
				beat.ack_checksum = tx.ack_checksum;
				beat.last = tx.last;
				check_result(beat);
			end
			if (rx.valid && rx.ready)
				absorb_byte(rx.rx_byte);
			pending <= result_q.size();
		end
	end

endmodule

FILE: verif/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import gbn_pkg::*;

	localparam int IN_BYTES    = 220;
	localparam int MAX_PACKETS = 40;
	localparam int DRAIN_LIMIT = 5000;
	localparam int SETTLE      = 20;

	typedef enum int {
		PK_IN_ORDER,
		PK_STALE,
		PK_OVERSIZE,
		PK_BIT_FLIP,
		PK_NOISE
	} pkt_kind_t;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;

	logic [BYTE_W-1:0] pkt [PACKET_BYTES];
	logic [ACK_W-1:0]  seq_next;
	bit                rx_quiet;
	bit                tx_quiet;

	gbn_in_if  rx_ch();
	gbn_out_if tx_ch();

	go_back_n_packet_receiver u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.tx     (tx_ch)
	);

	gbn_rx_checker u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.tx      (tx_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL go_back_n_packet_receiver");
		$finish;
	end

	function automatic logic [CS_W-1:0] packet_checksum();
		logic [31:0] s;
		s = 0;
		for (int i = 0; i < PACKET_BYTES; i++)
			if (i != CSUM_HI && i != CSUM_LO)
				s += (i % 2) ? {16'h0, pkt[i], 8'h00} : {24'h0, pkt[i]};
		s = {16'h0, s[31:16]} + {16'h0, s[15:0]};
		s = {16'h0, s[31:16]} + {16'h0, s[15:0]};
		return ~s[15:0];
	endfunction

	task automatic seal_packet();
		logic [CS_W-1:0] cs;
		cs = packet_checksum();
		pkt[CSUM_HI] = cs[15:8];
		pkt[CSUM_LO] = cs[7:0];
	endtask

	task automatic make_packet(input int unsigned size, input logic [ACK_W-1:0] seq);
		for (int i = 0; i < PACKET_BYTES; i++)
			pkt[i] = 8'($urandom);
		pkt[0] = size[7:0];
		{pkt[1], pkt[2], pkt[3], pkt[4]} = seq;
		seal_packet();
	endtask

	function automatic int unsigned pick_size();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return MAX_PAYLOAD;
		return $urandom_range(1, MAX_PAYLOAD - 1);
	endfunction

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = rx_quiet ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!(rx_ch.valid && rx_ch.ready));
	endtask

	// track the in-order number so most random packets get past the sequence check
	task automatic send_packet();
		bit good;
		logic [ACK_W-1:0] seq;
		seq = {pkt[1], pkt[2], pkt[3], pkt[4]};
		good = pkt[0] <= MAX_PAYLOAD && packet_checksum() == {pkt[CSUM_HI], pkt[CSUM_LO]};
		if (good && seq == seq_next)
			seq_next = seq_next + 1;
		for (int i = 0; i < PACKET_BYTES; i++)
			send_byte(pkt[i]);
	endtask

	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				tx_quiet = !tx_quiet;
			stall = tx_quiet ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				tx_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			tx_ch.ready <= 1'b1;
			do @(posedge clk); while (!(tx_ch.valid && tx_ch.ready));
		end
	end

	initial begin
		int in_bytes;
		int packets;
		int flip_at;
		int n;
		pkt_kind_t pk;

		arst_n <= 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		tx_ch.ready <= 1'b0;
		seq_next = 1;
		rx_quiet = 1'b1;
		tx_quiet = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corrupt while still expecting 1: no answer at all
		make_packet(3, 1);
		pkt[CSUM_LO] ^= 8'h01;
		send_packet();
		// good but out of order: ACK of 0
		make_packet(0, 32'hFFFF_FFFF);
		send_packet();
		// in order, full payload of alternating extremes
		make_packet(MAX_PAYLOAD, 1);
		for (int i = 0; i < MAX_PAYLOAD; i++)
			pkt[HDR_LEN + i] = i[0] ? 8'hFF : 8'h00;
		seal_packet();
		send_packet();
		rx_quiet = 1'b0;

		in_bytes = 3 * PACKET_BYTES;
		packets = 0;
		while (in_bytes < IN_BYTES && packets < MAX_PACKETS) begin
			rx_quiet = ($urandom_range(0, 3) == 0);
			n = $urandom_range(0, 99);
			if (n < 60)
				pk = PK_IN_ORDER;
			else if (n < 70)
				pk = PK_STALE;
			else if (n < 80)
				pk = PK_OVERSIZE;
			else if (n < 90)
				pk = PK_BIT_FLIP;
			else
				pk = PK_NOISE;
			case (pk)
				PK_IN_ORDER: make_packet(pick_size(), seq_next);
				PK_STALE: make_packet(pick_size(),
					$urandom_range(0, 1) ? seq_next - 1 : seq_next + $urandom_range(1, 3));
				PK_OVERSIZE: make_packet($urandom_range(MAX_PAYLOAD + 1, 255), seq_next);
				PK_BIT_FLIP: begin
					make_packet(pick_size(), seq_next);
					flip_at = $urandom_range(0, PACKET_BYTES - 1);
					pkt[flip_at] ^= 8'(1 << $urandom_range(0, 7));
				end
				default: begin
					for (int i = 0; i < PACKET_BYTES; i++)
						pkt[i] = 8'($urandom);
				end
			endcase
			send_packet();
			in_bytes += PACKET_BYTES;
			packets++;
		end
		rx_ch.valid <= 1'b0;

		// let the last byte reach the checker before trusting the pending count
		@(posedge clk);
		n = 0;
		while (pending != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS go_back_n_packet_receiver");
		else
			$display("FAIL go_back_n_packet_receiver");
		$finish;
	end

endmodule
